[hw/rtl/world_to_screen_projection_core_defines.svh]
// ----------------------------------------------------------------------------
// World-to-screen projection core: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define WSP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("world_to_screen_projection_core: check failed");

// Implication after a fixed number of cycles, disabled in reset
`define WSP_ASSERT_DLY(label, clk, rst, a, n, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("world_to_screen_projection_core: check failed");

`endif

[hw/rtl/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// Widths, register indexes and shared types of the projection core.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int WORD_W   = 32;   // Q16.16 coefficient and coordinate
  localparam int PROD_W   = 64;   // Q32.32 product
  localparam int SHR      = 16;   // product back to Q16.16
  localparam int ACC_W    = 50;   // dot product sum, full width
  localparam int DIM_W    = 14;   // viewport size
  localparam int NUM_W    = 64;   // dot product times viewport size
  localparam int MAG_W    = 63;   // numerator magnitude
  localparam int DEN_W    = 49;   // divisor (w, known positive when visible)
  localparam int FRAC_SH  = 15;   // numerator scale of 32768
  localparam int QB       = 34;   // quotient bits kept
  localparam int OVF_SH   = QB - FRAC_SH;
  localparam int Q_W      = QB + 2;
  localparam int SCR_W    = 38;
  localparam int OUT_W    = 32;
  localparam int HALF_Q   = 32768;
  localparam int W_MIN    = 66;   // 0.001 in Q16.16, rounded up
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam int DOT_LAT  = 3;
  localparam int PREP_LAT = 3;
  localparam int OUT_LAT  = 2;
  localparam int LATENCY  = DOT_LAT + PREP_LAT + QB + OUT_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_A,
    REG_ROW0_B,
    REG_ROW1_A,
    REG_ROW1_B,
    REG_ROWW_A,
    REG_ROWW_B,
    REG_SCREEN_W,
    REG_SCREEN_H
  } reg_idx_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [QB-1:0]            quo_t;
  typedef logic [DIM_W-1:0]         dim_t;

  typedef struct packed {
    logic vis;   // point in front of the viewer
    logic neg;   // numerator negative
    logic ovf;   // quotient far outside the output range
  } div_tag_t;

endpackage

[hw/rtl/wsp_dot.sv]
// ----------------------------------------------------------------------------
// wsp_dot
// Three-stage dot products of the point with matrix rows 0, 1 and 3.
// ----------------------------------------------------------------------------
module wsp_dot (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  wsp_pkg::word_t coef [3][4],
  input  wsp_pkg::word_t pt [3],
  output logic          out_valid,
  output wsp_pkg::acc_t acc [3]
);
  import wsp_pkg::*;

  logic signed [PROD_W-1:0] prod [3][3];
  word_t                    trans [3];
  acc_t                     sum_a [3];
  acc_t                     sum_b [3];
  logic                     v1, v2;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Multiply, then floor-shift and pair up, then add the pairs
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= coef[r][k] * pt[k];
      end
      trans[r] <= coef[r][3];
      sum_a[r] <= ACC_W'($signed(prod[r][0][PROD_W-1:SHR]))
                + ACC_W'($signed(prod[r][1][PROD_W-1:SHR]));
      sum_b[r] <= ACC_W'($signed(prod[r][2][PROD_W-1:SHR])) + ACC_W'(trans[r]);
      acc[r]   <= sum_a[r] + sum_b[r];
    end
  end

endmodule

[hw/rtl/wsp_prep.sv]
// ----------------------------------------------------------------------------
// wsp_prep
// Scale x and y by the viewport size, split off signs, test w and
// flag quotients that land far outside the output range.
// ----------------------------------------------------------------------------
module wsp_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  wsp_pkg::acc_t     xq,
  input  wsp_pkg::acc_t     yq,
  input  wsp_pkg::acc_t     wq,
  input  wsp_pkg::dim_t     wd,
  input  wsp_pkg::dim_t     hd,
  output logic              out_valid,
  output wsp_pkg::den_t     den,
  output wsp_pkg::mag_t     mag_x,
  output wsp_pkg::mag_t     mag_y,
  output wsp_pkg::div_tag_t tag_x,
  output wsp_pkg::div_tag_t tag_y
);
  import wsp_pkg::*;

  logic signed [NUM_W-1:0] nx, ny;
  acc_t                    w1;
  logic                    v1, v2;
  den_t                    den2;
  mag_t                    mx2, my2;
  logic                    nxg2, nyg2, vis2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: scale by viewport size
  always_ff @(posedge clk) begin
    nx <= xq * $signed({1'b0, wd});
    ny <= yq * $signed({1'b0, hd});
    w1 <= wq;
  end

  // Stage 2: magnitudes, signs and the behind-viewer test
  always_ff @(posedge clk) begin
    nxg2 <= nx[NUM_W-1];
    nyg2 <= ny[NUM_W-1];
    mx2  <= nx[NUM_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
    my2  <= ny[NUM_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
    vis2 <= (w1 >= ACC_W'(W_MIN));
    den2 <= DEN_W'(w1);
  end

  // Stage 3: quotient range check against den << OVF_SH
  always_ff @(posedge clk) begin
    den       <= den2;
    mag_x     <= mx2;
    mag_y     <= my2;
    tag_x.vis <= vis2;
    tag_x.neg <= nxg2;
    tag_x.ovf <= (DEN_W+OVF_SH)'(mx2) >= {den2, {OVF_SH{1'b0}}};
    tag_y.vis <= vis2;
    tag_y.neg <= nyg2;
    tag_y.ovf <= (DEN_W+OVF_SH)'(my2) >= {den2, {OVF_SH{1'b0}}};
  end

endmodule

[hw/rtl/wsp_div.sv]
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider: floor(mag * 32768 / den), one quotient
// bit per stage, plus a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  wsp_pkg::den_t     den,
  input  wsp_pkg::mag_t     mag,
  input  wsp_pkg::div_tag_t in_tag,
  output logic              out_valid,
  output wsp_pkg::quo_t     quo,
  output logic              rem_nz,
  output wsp_pkg::div_tag_t out_tag
);
  import wsp_pkg::*;

  logic     vld_s [QB];
  den_t     den_s [QB-1];
  den_t     rem_s [QB];
  quo_t     nq_s  [QB];   // numerator bits left, quotient bits shifted in
  div_tag_t tag_s [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic           v_in;
    den_t           d_in;
    den_t           r_in;
    quo_t           nq_in;
    div_tag_t       t_in;
    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;

    if (i == 0) begin : g_first
      assign v_in  = in_valid;
      assign d_in  = den;
      assign r_in  = DEN_W'(mag[MAG_W-1:OVF_SH]);
      assign nq_in = {mag[OVF_SH-1:0], {FRAC_SH{1'b0}}};
      assign t_in  = in_tag;
    end else begin : g_rest
      assign v_in  = vld_s[i-1];
      assign d_in  = den_s[i-1];
      assign r_in  = rem_s[i-1];
      assign nq_in = nq_s[i-1];
      assign t_in  = tag_s[i-1];
    end

    // Bring down one bit, subtract if it fits
    assign shifted = {r_in, nq_in[QB-1]};
    assign diff    = shifted - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i] <= 1'b0;
      end else begin
        vld_s[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_s[i] <= diff[DEN_W] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
      nq_s[i]  <= {nq_in[QB-2:0], ~diff[DEN_W]};
      tag_s[i] <= t_in;
    end

    if (i < QB - 1) begin : g_den
      always_ff @(posedge clk) begin
        den_s[i] <= d_in;
      end
    end
  end

  assign out_valid = vld_s[QB-1];
  assign quo       = nq_s[QB-1];
  assign rem_nz    = |rem_s[QB-1];
  assign out_tag   = tag_s[QB-1];

endmodule

[hw/rtl/wsp_out.sv]
// ----------------------------------------------------------------------------
// wsp_out
// Signed floor of the quotients, viewport offsets and clipping to the
// Q16.16 output range.
// ----------------------------------------------------------------------------
module wsp_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wsp_pkg::quo_t      quo_x,
  input  logic               rem_nz_x,
  input  wsp_pkg::div_tag_t  tag_x,
  input  wsp_pkg::quo_t      quo_y,
  input  logic               rem_nz_y,
  input  wsp_pkg::div_tag_t  tag_y,
  input  wsp_pkg::dim_t      wd,
  input  wsp_pkg::dim_t      hd,
  output logic               done,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               visible,
  output logic               saturated
);
  import wsp_pkg::*;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [Q_W-1:0]   qs_x, qs_y;
  div_tag_t                tx1, ty1;
  logic                    v1;
  logic [DIM_W+SHR-2:0]    half_w, half_h;
  logic signed [SCR_W-1:0] sx, sy;
  logic                    rng_x, rng_y, sat_x, sat_y;
  logic [OUT_W-1:0]        cx, cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= in_valid;
      done <= v1;
    end
  end

  // Stage 1: negative numerators round toward minus infinity
  always_ff @(posedge clk) begin
    qs_x <= tag_x.neg ? -(Q_W'(quo_x) + Q_W'(rem_nz_x)) : Q_W'(quo_x);
    qs_y <= tag_y.neg ? -(Q_W'(quo_y) + Q_W'(rem_nz_y)) : Q_W'(quo_y);
    tx1  <= tag_x;
    ty1  <= tag_y;
  end

  // Viewport offsets and range checks
  always_comb begin
    half_w = {wd[DIM_W-1:1], {SHR{1'b0}}};
    half_h = {hd[DIM_W-1:1], {SHR{1'b0}}};
    sx     = SCR_W'(half_w) + SCR_W'(qs_x) + SCR_W'(HALF_Q);
    sy     = SCR_W'(half_h) - (SCR_W'(qs_y) + SCR_W'(HALF_Q));
    rng_x  = (&sx[SCR_W-1:OUT_W-1]) || !(|sx[SCR_W-1:OUT_W-1]);
    rng_y  = (&sy[SCR_W-1:OUT_W-1]) || !(|sy[SCR_W-1:OUT_W-1]);
    // A huge quotient saturates by its sign; y runs the other way
    sat_x  = tx1.ovf || !rng_x;
    sat_y  = ty1.ovf || !rng_y;
    if (tx1.ovf) begin
      cx = tx1.neg ? OUT_MIN : OUT_MAX;
    end else if (!rng_x) begin
      cx = sx[SCR_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      cx = sx[OUT_W-1:0];
    end
    if (ty1.ovf) begin
      cy = ty1.neg ? OUT_MAX : OUT_MIN;
    end else if (!rng_y) begin
      cy = sy[SCR_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      cy = sy[OUT_W-1:0];
    end
  end

  // Stage 2: result beat, zeroed for points behind the viewer
  always_ff @(posedge clk) begin
    visible <= tx1.vis;
    if (tx1.vis) begin
      screen_x  <= cx;
      screen_y  <= cy;
      saturated <= sat_x || sat_y;
    end else begin
      screen_x  <= '0;
      screen_y  <= '0;
      saturated <= 1'b0;
    end
  end

endmodule

[hw/rtl/world_to_screen_projection_core.sv]
// ----------------------------------------------------------------------------
// World-to-screen projection core
// Perspective projection of Q16.16 points to viewport pixels.
// ----------------------------------------------------------------------------
// Takes one point per clock: busy stays low, so every cycle with start
// high accepts a point. Each point yields one result beat, marked by done,
// after 3 dot-product stages, 3 scaling and range-check stages, 34 divider
// stages and 2 output stages; the divider pipeline, one quotient bit per
// stage, makes up most of that depth. Results leave in order and must be
// taken on the cycle they appear. Write configuration only while no point
// is in flight.
module world_to_screen_projection_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [31:0]        point_x,
  input  logic signed [31:0]        point_y,
  input  logic signed [31:0]        point_z,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_wdata,
  output logic                      done,
  output logic signed [31:0]        screen_x,
  output logic signed [31:0]        screen_y,
  output logic                      visible,
  output logic                      saturated
);
  import wsp_pkg::*;

  logic [CFG_W-1:0] row0_a, row0_b, row1_a, row1_b, roww_a, roww_b;
  dim_t             screen_width, screen_height;

  word_t    coef [3][4];
  word_t    pt [3];
  logic     dot_valid;
  acc_t     acc [3];
  logic     prep_valid;
  den_t     den;
  mag_t     mag_x, mag_y;
  div_tag_t tag_x, tag_y;
  logic     vx, vy;
  quo_t     quo_x, quo_y;
  logic     rnz_x, rnz_y;
  div_tag_t otag_x, otag_y;

  // Pipeline never stalls
  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_a        <= 64'd65536;
      row0_b        <= '0;
      row1_a        <= 64'd1 << 48;
      row1_b        <= '0;
      roww_a        <= '0;
      roww_b        <= 64'd1 << 48;
      screen_width  <= DIM_W'(1920);
      screen_height <= DIM_W'(1080);
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0_A:   row0_a        <= cfg_wdata;
        REG_ROW0_B:   row0_b        <= cfg_wdata;
        REG_ROW1_A:   row1_a        <= cfg_wdata;
        REG_ROW1_B:   row1_b        <= cfg_wdata;
        REG_ROWW_A:   roww_a        <= cfg_wdata;
        REG_ROWW_B:   roww_b        <= cfg_wdata;
        REG_SCREEN_W: screen_width  <= cfg_wdata[DIM_W-1:0];
        REG_SCREEN_H: screen_height <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficient pairs, low half first
  always_comb begin
    coef[0][0] = row0_a[31:0];  coef[0][1] = row0_a[63:32];
    coef[0][2] = row0_b[31:0];  coef[0][3] = row0_b[63:32];
    coef[1][0] = row1_a[31:0];  coef[1][1] = row1_a[63:32];
    coef[1][2] = row1_b[31:0];  coef[1][3] = row1_b[63:32];
    coef[2][0] = roww_a[31:0];  coef[2][1] = roww_a[63:32];
    coef[2][2] = roww_b[31:0];  coef[2][3] = roww_b[63:32];
    pt[0] = point_x;
    pt[1] = point_y;
    pt[2] = point_z;
  end

  wsp_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .coef      (coef),
    .pt        (pt),
    .out_valid (dot_valid),
    .acc       (acc)
  );

  wsp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dot_valid),
    .xq        (acc[0]),
    .yq        (acc[1]),
    .wq        (acc[2]),
    .wd        (screen_width),
    .hd        (screen_height),
    .out_valid (prep_valid),
    .den       (den),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .tag_x     (tag_x),
    .tag_y     (tag_y)
  );

  wsp_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .den       (den),
    .mag       (mag_x),
    .in_tag    (tag_x),
    .out_valid (vx),
    .quo       (quo_x),
    .rem_nz    (rnz_x),
    .out_tag   (otag_x)
  );

  wsp_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .den       (den),
    .mag       (mag_y),
    .in_tag    (tag_y),
    .out_valid (vy),
    .quo       (quo_y),
    .rem_nz    (rnz_y),
    .out_tag   (otag_y)
  );

  wsp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vx && vy),
    .quo_x     (quo_x),
    .rem_nz_x  (rnz_x),
    .tag_x     (otag_x),
    .quo_y     (quo_y),
    .rem_nz_y  (rnz_y),
    .tag_y     (otag_y),
    .wd        (screen_width),
    .hd        (screen_height),
    .done      (done),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .visible   (visible),
    .saturated (saturated)
  );

endmodule

[hw/rtl/wsp_checker.sv]
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks of the projection core, bound to the top level.
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_core_defines.svh"

module wsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] screen_x,
  input logic signed [31:0] screen_y,
  input logic               visible,
  input logic               saturated
);
  import wsp_pkg::*;

  logic hidden_ok;

  // A hidden point carries all-zero fields
  assign hidden_ok = screen_x == 32'sd0 && screen_y == 32'sd0 && !saturated;

  // Every accepted point comes out after the fixed latency
  `WSP_ASSERT_DLY(a_start_done, clk, rst, start && !busy, LATENCY, done)

  // No result beat without a point accepted that long ago
  `WSP_ASSERT_IMP(a_done_src, clk, rst, done, $past(start && !busy, LATENCY))

  // Points behind the viewer come out as zeros
  `WSP_ASSERT_IMP(a_hidden_zero, clk, rst, done && !visible, hidden_ok)

  // Clipping only happens on visible points
  `WSP_ASSERT_IMP(a_sat_visible, clk, rst, done && saturated, visible)

endmodule

bind world_to_screen_projection_core wsp_checker u_wsp_checker (.*);
